// ===== rtl/core/lfsr_ks_pkg.sv =====
// Shared types and constants for the configurable LFSR key stepper.
package lfsr_ks_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_WIDE_MODE      = 3'd0;
	localparam logic [2:0] REG_FIBONACCI_FORM = 3'd1;
	localparam logic [2:0] REG_SHIFT_LEFT     = 3'd2;
	localparam logic [2:0] REG_TAP_MASK       = 3'd3;
	localparam logic [2:0] REG_SEED           = 3'd4;

	localparam int unsigned KEY_W   = 16;
	localparam int unsigned COUNT_W = 17;

	localparam logic [KEY_W-1:0]   MASK_WIDE        = 16'hFFFF;
	localparam logic [KEY_W-1:0]   MASK_NARROW      = 16'h00FF;
	localparam logic [KEY_W-1:0]   TOP_WIDE         = 16'h8000;
	localparam logic [KEY_W-1:0]   TOP_NARROW       = 16'h0080;
	localparam logic [COUNT_W-1:0] ROUND_LIMIT_WIDE = 17'h10000;

	// Generator configuration as seen by the step logic
	typedef struct packed {
		logic             wide_mode;
		logic             fibonacci_form;
		logic             shift_left;
		logic [KEY_W-1:0] tap_mask;
	} lfsr_cfg_t;

endpackage

// ===== rtl/core/configurable_lfsr_key_stepper.sv =====
// Top level of the configurable LFSR key stepper: config, run state and result register.
//
// Usage: write the five registers (wide_mode, fibonacci_form, shift_left,
// tap_mask, seed) through cfg_we / cfg_index / cfg_data while the block is
// idle. Each item on the input channel (in_valid / in_ready) carries one
// restart bit and produces exactly one result item on the output channel
// (out_valid / out_ready): the current key, its round index, active and last.
// An item with restart set loads the seed and starts a run; once a result
// with last set has gone out, further items return an all-zero, inactive
// result until the next restart.
// The result of an item is registered and presented in the cycle after acceptance.
// Throughput: one item per cycle; the run state (key, round count, ended
// flag) updates through the combinational step logic, which sets the
// rate. in_ready is high whenever the result register is empty or is being
// taken in the same cycle, so a stalled receiver holds at most one result and
// back-pressures the input. After reset the configuration, key and round
// count are zero, no run is in progress and the output channel is empty.
module configurable_lfsr_key_stepper import lfsr_ks_pkg::*; #(
	parameter int unsigned ROUND_LIMIT_NARROW = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [KEY_W-1:0]   cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [KEY_W-1:0]   key_value,
	output logic [KEY_W-1:0]   round_index,
	output logic               active,
	output logic               last
);

	localparam logic [COUNT_W-1:0] LIMIT_NARROW = COUNT_W'(ROUND_LIMIT_NARROW);

	lfsr_cfg_t        cfg_q;
	logic [KEY_W-1:0] seed_q;

	logic [KEY_W-1:0]   key_q;
	logic [COUNT_W-1:0] count_q;
	logic               run_ended_q;

	logic               out_valid_q;
	logic [KEY_W-1:0]   key_value_q;
	logic [KEY_W-1:0]   round_index_q;
	logic               active_q;
	logic               last_q;

	logic               in_fire;
	logic [KEY_W-1:0]   mask;
	logic [KEY_W-1:0]   seed_w;
	logic [COUNT_W-1:0] limit;
	logic [KEY_W-1:0]   key_cur;
	logic [COUNT_W-1:0] count_cur;
	logic               ended_cur;
	logic [KEY_W-1:0]   nk;
	logic [COUNT_W-1:0] count_inc;
	logic               run_end;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= '0;
			seed_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDE_MODE:      cfg_q.wide_mode      <= cfg_data[0];
				REG_FIBONACCI_FORM: cfg_q.fibonacci_form <= cfg_data[0];
				REG_SHIFT_LEFT:     cfg_q.shift_left     <= cfg_data[0];
				REG_TAP_MASK:       cfg_q.tap_mask       <= cfg_data;
				REG_SEED:           seed_q               <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_fire = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	// Apply restart ahead of the step
	always_comb begin
		mask   = cfg_q.wide_mode ? MASK_WIDE : MASK_NARROW;
		limit  = cfg_q.wide_mode ? ROUND_LIMIT_WIDE : LIMIT_NARROW;
		seed_w = seed_q & mask;
		if (restart) begin
			key_cur   = seed_w;
			count_cur = '0;
			ended_cur = 1'b0;
		end else begin
			key_cur   = key_q & mask;
			count_cur = count_q;
			ended_cur = run_ended_q;
		end
	end

	lfsr_ks_step u_step (
		.cfg      (cfg_q),
		.key      (key_cur),
		.next_key (nk)
	);

	// Test for the end of the run
	always_comb begin
		count_inc = count_cur + COUNT_W'(1);
		run_end   = (count_inc >= limit) || (nk == '0) || (nk == seed_w);
	end

	// Advance run state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= '0;
			count_q     <= '0;
			run_ended_q <= 1'b1;
		end else if (in_fire && !ended_cur) begin
			key_q       <= nk;
			count_q     <= count_inc;
			run_ended_q <= run_end;
		end
	end

	// Hold result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (ended_cur) begin
				key_value_q   <= '0;
				round_index_q <= '0;
				active_q      <= 1'b0;
				last_q        <= 1'b0;
			end else begin
				key_value_q   <= key_cur;
				round_index_q <= count_cur[KEY_W-1:0];
				active_q      <= 1'b1;
				last_q        <= run_end;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign key_value   = key_value_q;
	assign round_index = round_index_q;
	assign active      = active_q;
	assign last        = last_q;

	// Checks on run state and results
	a_restart_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && restart) |=> (out_valid && active && round_index == '0))
		else $error("restart item did not give an active first key at round zero");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !ended_cur && run_end) |=> run_ended_q)
		else $error("run did not end after a last key");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !active) |-> (key_value == '0 && round_index == '0 && !last))
		else $error("inactive result carries nonzero fields");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ROUND_LIMIT_WIDE)
		else $error("round count passed the wide limit");

	a_ended_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(run_ended_q && !(in_fire && restart)) |=> (run_ended_q && $stable(key_q)))
		else $error("ended run changed state without restart");

endmodule

// ===== rtl/core/lfsr_ks_step.sv =====
// Next-key logic: one Galois or Fibonacci LFSR step, 8 or 16 bits, either direction.
module lfsr_ks_step import lfsr_ks_pkg::*; (
	input  lfsr_cfg_t        cfg,
	input  logic [KEY_W-1:0] key,
	output logic [KEY_W-1:0] next_key
);

	logic [KEY_W-1:0] mask;
	logic [KEY_W-1:0] top;
	logic [KEY_W-1:0] taps;
	logic [KEY_W-1:0] key_w;
	logic             top_bit;
	logic             fb;
	logic [KEY_W-1:0] raw;

	// Select width-dependent masks
	always_comb begin
		mask    = cfg.wide_mode ? MASK_WIDE : MASK_NARROW;
		top     = cfg.wide_mode ? TOP_WIDE : TOP_NARROW;
		taps    = cfg.tap_mask & mask;
		key_w   = key & mask;
		top_bit = |(key_w & top);
		fb      = ^(key_w & taps);
	end

	// Advance the key by one step
	always_comb begin
		case ({cfg.fibonacci_form, cfg.shift_left})
			2'b11: raw = {key_w[KEY_W-2:0], fb};
			2'b10: raw = (key_w >> 1) | (fb ? top : '0);
			2'b01: raw = {key_w[KEY_W-2:0], 1'b0} ^ (top_bit ? taps : '0);
			2'b00: raw = (key_w >> 1) ^ (key_w[0] ? taps : '0);
			default: raw = '0;
		endcase
		next_key = raw & mask;
	end

endmodule
